// ----- rtl/ppg_pkg.sv -----
// Shared constants, types and the quarter-wave sine table of the plasma pixel generator.
package ppg_pkg;

  localparam int MAX_DIM          = 4096;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

  localparam int COORD_W = 12;
  localparam int PITCH_W = 13;
  localparam int TIME_W  = 32;
  localparam int PIX_W   = 24;
  localparam int ADDR_W  = 24;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

  // Angles are unsigned 32-bit turns.
  localparam logic [24:0] K_X  = 25'd21361415;
  localparam logic [24:0] K_Y  = 25'd28481886;
  localparam logic [23:0] K_XY = 24'd14240943;
  localparam logic [24:0] K_R  = 25'd17089132;
  localparam logic [29:0] R_T10 = 30'd683565276;
  localparam logic [29:0] R_T13 = 30'd888634858;
  localparam logic [29:0] R_T07 = 30'd478495693;
  localparam logic [31:0] OFS_G = 32'd1367130551;
  localparam logic [31:0] OFS_B = 32'd2734261102;

  // Square root: 21 steps, three per pipeline stage.
  localparam int ROOT_W            = 42;
  localparam int SQRT_STEPS        = 21;
  localparam int SQRT_STEPS_STAGE  = 3;
  localparam int SQRT_STAGES       = SQRT_STEPS / SQRT_STEPS_STAGE;
  localparam int NUM_STAGES        = SQRT_STAGES + 8;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_table_t [SINE_TABLE_DEPTH];

  // Taylor series of the sine at the center of entry i, rounded to Q15.
  function automatic logic [14:0] sine_entry(int unsigned i);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic signed [63:0] s;
    logic [63:0] q;
    // The divisor is twice the table depth, a power of two.
    a  = (64'(2 * i + 1) * HALF_PI_Q30) >> (SINE_IDX_W + 1);
    a2 = (a * a) >> 30;
    t3 = ((a * a2) >> 30) / 64'd6;
    t5 = ((t3 * a2) >> 30) / 64'd20;
    t7 = ((t5 * a2) >> 30) / 64'd42;
    t9 = ((t7 * a2) >> 30) / 64'd72;
    s  = $signed(a) - $signed(t3) + $signed(t5) - $signed(t7) + $signed(t9);
    if (s <= 0) begin
      q = 64'd0;
    end else begin
      q = (64'(s) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
    end
    return q[14:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- rtl/ppg_in_if.sv -----
// Request channel carrying one pixel coordinate and frame time.
interface ppg_in_if;
  logic                              valid;
  logic                              ready;
  logic [ppg_pkg::COORD_W-1:0]       pixel_column;
  logic [ppg_pkg::COORD_W-1:0]       pixel_row;
  logic [ppg_pkg::TIME_W-1:0]        frame_time;

  modport source (output valid, output pixel_column, output pixel_row, output frame_time,
                  input ready);
  modport sink (input valid, input pixel_column, input pixel_row, input frame_time,
                output ready);
endinterface

// ----- rtl/ppg_out_if.sv -----
// Result channel carrying one packed pixel and its word address.
interface ppg_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppg_pkg::PIX_W-1:0]     pixel_word;
  logic [ppg_pkg::ADDR_W-1:0]    word_address;

  modport source (output valid, output pixel_word, output word_address, input ready);
  modport sink (input valid, input pixel_word, input word_address, output ready);
endinterface

// ----- rtl/plasma_pixel_generator_top.sv -----
// Top level of the plasma pixel generator: a fifteen-stage pipeline.
//
// Usage: each request on pix_in carries a pixel column, a pixel row and a
// frame time in Q16.16 seconds. The block sums four sine waves (in x, in y,
// in x+y and in the radial distance), turns the sum into red, green and blue
// through three phase-shifted sines, and returns the packed pixel together
// with the word address row * pitch + column on pix_out.
// The row pitch is set through cfg_wr_en and cfg_wr_data; write it only while
// no request is in flight. It resets to 640.
// Throughput is one request per clock while pix_out is not stalled. A result
// is presented on pix_out in request order; the depth is set by the
// seven square-root stages plus the multiply, table and color stages.
// Every stage has a valid bit. When the receiver stalls, stages that hold
// data keep it while empty stages in front of them still fill, so new
// requests are accepted until the whole pipeline is full.
// A synchronous reset clears all valid bits and restores the pitch.
module plasma_pixel_generator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ppg_pkg::PITCH_W-1:0]   cfg_wr_data,
  ppg_in_if.sink                        pix_in,
  ppg_out_if.source                     pix_out
);

  localparam int NST  = ppg_pkg::NUM_STAGES;
  localparam int LAST = NST - 1;
  localparam int SQ0  = 2;

  typedef struct packed {
    logic [31:0]                p1;
    logic [31:0]                p2;
    logic [31:0]                p3;
    logic [31:0]                tp10;
    logic [ppg_pkg::ADDR_W-1:0] addr;
  } carry_t;

  logic [ppg_pkg::PITCH_W-1:0] pitch;
  logic [NST-1:0]              vld;
  logic [NST-1:0]              free;

  // Stage 0 signals.
  logic [ppg_pkg::COORD_W-1:0] x_sat;
  logic [ppg_pkg::COORD_W-1:0] y_sat;
  logic [61:0]                 m10;
  logic [61:0]                 m13;
  logic [61:0]                 m07;
  logic [36:0]                 mx;
  logic [36:0]                 my;
  logic [36:0]                 mxy;
  logic [ppg_pkg::COORD_W-1:0] x0;
  logic [31:0]                 tp10_0;
  logic [31:0]                 tp13_0;
  logic [31:0]                 tp07_0;
  logic [31:0]                 cx0;
  logic [31:0]                 cy0;
  logic [31:0]                 cxy0;
  logic [23:0]                 xx0;
  logic [23:0]                 yy0;
  logic [24:0]                 yp0;

  // Stage 1 and the square-root chain.
  carry_t                      carry [1:SQ0+ppg_pkg::SQRT_STAGES-1];
  logic [ppg_pkg::ROOT_W-1:0]  rem [1:SQ0+ppg_pkg::SQRT_STAGES-1];
  logic [ppg_pkg::ROOT_W-1:0]  root [1:SQ0+ppg_pkg::SQRT_STAGES-1];

  // Radial phase, table and color stages.
  logic [45:0]                 mr;
  logic [31:0]                 rk9;
  carry_t                      carry9;
  logic [31:0]                 p1_10;
  logic [31:0]                 p2_10;
  logic [31:0]                 p3_10;
  logic [31:0]                 p4_10;
  logic [ppg_pkg::ADDR_W-1:0]  addr10;
  logic signed [15:0]          s1;
  logic signed [15:0]          s2;
  logic signed [15:0]          s3;
  logic signed [15:0]          s4;
  logic [ppg_pkg::ADDR_W-1:0]  addr11;
  logic [15:0]                 v12;
  logic [ppg_pkg::ADDR_W-1:0]  addr12;
  logic [31:0]                 ph_r;
  logic [31:0]                 ph_g;
  logic [31:0]                 ph_b;
  logic signed [15:0]          sr;
  logic signed [15:0]          sg;
  logic signed [15:0]          sb;
  logic [ppg_pkg::ADDR_W-1:0]  addr13;
  logic [22:0]                 num_r;
  logic [22:0]                 num_g;
  logic [22:0]                 num_b;
  logic [ppg_pkg::PIX_W-1:0]   pix14;
  logic [ppg_pkg::ADDR_W-1:0]  addr14;

  // Pitch register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= ppg_pkg::PITCH_RESET;
    end else if (cfg_wr_en) begin
      pitch <= cfg_wr_data;
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    free[LAST] = !vld[LAST] || pix_out.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (free[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (free[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pix_in.ready = free[0];

  // Stage 0: saturate the coordinates and form the time and coordinate products.
  assign x_sat = (13'(pix_in.pixel_column) >= 13'(ppg_pkg::MAX_DIM))
               ? ppg_pkg::COORD_W'(ppg_pkg::MAX_DIM - 1) : pix_in.pixel_column;
  assign y_sat = (13'(pix_in.pixel_row) >= 13'(ppg_pkg::MAX_DIM))
               ? ppg_pkg::COORD_W'(ppg_pkg::MAX_DIM - 1) : pix_in.pixel_row;
  assign m10 = 62'(pix_in.frame_time) * 62'(ppg_pkg::R_T10);
  assign m13 = 62'(pix_in.frame_time) * 62'(ppg_pkg::R_T13);
  assign m07 = 62'(pix_in.frame_time) * 62'(ppg_pkg::R_T07);
  assign mx  = 37'(x_sat) * 37'(ppg_pkg::K_X);
  assign my  = 37'(y_sat) * 37'(ppg_pkg::K_Y);
  assign mxy = 37'(13'(x_sat) + 13'(y_sat)) * 37'(ppg_pkg::K_XY);

  always_ff @(posedge clk) begin
    if (free[0]) begin
      x0     <= x_sat;
      tp10_0 <= m10[47:16];
      tp13_0 <= m13[47:16];
      tp07_0 <= m07[47:16];
      cx0    <= mx[31:0];
      cy0    <= my[31:0];
      cxy0   <= mxy[31:0];
      xx0    <= 24'(x_sat) * 24'(x_sat);
      yy0    <= 24'(y_sat) * 24'(y_sat);
      yp0    <= 25'(y_sat) * 25'(pitch);
    end
  end

  // Stage 1: linear phases, address and the radicand.
  always_ff @(posedge clk) begin
    if (free[1]) begin
      carry[1].p1   <= cx0 + tp10_0;
      carry[1].p2   <= cy0 + tp13_0;
      carry[1].p3   <= cxy0 + tp07_0;
      carry[1].tp10 <= tp10_0;
      carry[1].addr <= ppg_pkg::ADDR_W'(yp0 + 25'(x0));
      rem[1]        <= ppg_pkg::ROOT_W'({25'(xx0) + 25'(yy0), 16'd0});
      root[1]       <= '0;
    end
  end

  // Stages 2 to 8: square root of (x*x + y*y) << 16.
  for (genvar s = 0; s < ppg_pkg::SQRT_STAGES; s++) begin : g_sqrt
    ppg_sqrt_stage u_sqrt (
      .clk       (clk),
      .en        (free[SQ0+s]),
      .step_base (5'(s * ppg_pkg::SQRT_STEPS_STAGE)),
      .rem_in    (rem[SQ0+s-1]),
      .root_in   (root[SQ0+s-1]),
      .rem_out   (rem[SQ0+s]),
      .root_out  (root[SQ0+s])
    );

    always_ff @(posedge clk) begin
      if (free[SQ0+s]) begin
        carry[SQ0+s] <= carry[SQ0+s-1];
      end
    end
  end

  // Stage 9: radial phase from the Q8 root.
  assign mr = 46'(root[SQ0+ppg_pkg::SQRT_STAGES-1][20:0]) * 46'(ppg_pkg::K_R);

  always_ff @(posedge clk) begin
    if (free[9]) begin
      rk9    <= mr[39:8];
      carry9 <= carry[SQ0+ppg_pkg::SQRT_STAGES-1];
    end
  end

  // Stage 10: the radial term runs backwards in time.
  always_ff @(posedge clk) begin
    if (free[10]) begin
      p1_10  <= carry9.p1;
      p2_10  <= carry9.p2;
      p3_10  <= carry9.p3;
      p4_10  <= rk9 - carry9.tp10;
      addr10 <= carry9.addr;
    end
  end

  // Stage 11: four sine lookups.
  ppg_sine_rom u_sin1 (.clk(clk), .en(free[11]), .phase(p1_10), .sine(s1));
  ppg_sine_rom u_sin2 (.clk(clk), .en(free[11]), .phase(p2_10), .sine(s2));
  ppg_sine_rom u_sin3 (.clk(clk), .en(free[11]), .phase(p3_10), .sine(s3));
  ppg_sine_rom u_sin4 (.clk(clk), .en(free[11]), .phase(p4_10), .sine(s4));

  always_ff @(posedge clk) begin
    if (free[11]) begin
      addr11 <= addr10;
    end
  end

  // Stage 12: only the low 16 bits of the sum survive the shift into turns.
  always_ff @(posedge clk) begin
    if (free[12]) begin
      v12    <= 16'(s1 + s2 + s3 + s4);
      addr12 <= addr11;
    end
  end

  // Stage 13: three color sines with fixed phase offsets.
  assign ph_r = {v12, 16'd0};
  assign ph_g = ph_r + ppg_pkg::OFS_G;
  assign ph_b = ph_r + ppg_pkg::OFS_B;

  ppg_sine_rom u_sinr (.clk(clk), .en(free[13]), .phase(ph_r), .sine(sr));
  ppg_sine_rom u_sing (.clk(clk), .en(free[13]), .phase(ph_g), .sine(sg));
  ppg_sine_rom u_sinb (.clk(clk), .en(free[13]), .phase(ph_b), .sine(sb));

  always_ff @(posedge clk) begin
    if (free[13]) begin
      addr13 <= addr12;
    end
  end

  // Stage 14: 127 * (32768 + s) >> 15; adding 32768 flips the sign bit.
  assign num_r = 23'({~sr[15], sr[14:0]}) * 23'd127;
  assign num_g = 23'({~sg[15], sg[14:0]}) * 23'd127;
  assign num_b = 23'({~sb[15], sb[14:0]}) * 23'd127;

  always_ff @(posedge clk) begin
    if (free[14]) begin
      pix14  <= {num_r[22:15], num_g[22:15], num_b[22:15]};
      addr14 <= addr13;
    end
  end

  assign pix_out.valid        = vld[LAST];
  assign pix_out.pixel_word   = pix14;
  assign pix_out.word_address = addr14;

`ifndef SYNTHESIS
  // Requests are refused only when every stage holds an item.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (&vld))
    else $error("request refused while the pipeline has an empty stage");

  // Reset empties the pipeline, so a request is taken right after it.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> pix_in.ready)
    else $error("pipeline not empty after reset");

  // A pitch write lands in the register.
  a_pitch_write: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(cfg_wr_en) |-> pitch == $past(cfg_wr_data))
    else $error("pitch register lost a write");
`endif

endmodule

// ----- rtl/ppg_sqrt_stage.sv -----
// One registered stage of the bit-by-bit square root, three steps per stage.
module ppg_sqrt_stage (
  input  logic                        clk,
  input  logic                        en,
  input  logic [4:0]                  step_base,
  input  logic [ppg_pkg::ROOT_W-1:0]  rem_in,
  input  logic [ppg_pkg::ROOT_W-1:0]  root_in,
  output logic [ppg_pkg::ROOT_W-1:0]  rem_out,
  output logic [ppg_pkg::ROOT_W-1:0]  root_out
);

  logic [ppg_pkg::ROOT_W-1:0] rem_next;
  logic [ppg_pkg::ROOT_W-1:0] root_next;
  logic [ppg_pkg::ROOT_W-1:0] bit_val;
  logic [ppg_pkg::ROOT_W-1:0] trial;
  logic [4:0]                 step_idx;
  logic [5:0]                 shamt;

  always_comb begin
    rem_next  = rem_in;
    root_next = root_in;
    bit_val   = '0;
    trial     = '0;
    step_idx  = '0;
    shamt     = '0;
    for (int k = 0; k < ppg_pkg::SQRT_STEPS_STAGE; k++) begin
      step_idx = step_base + 5'(k);
      shamt    = 6'd40 - {step_idx, 1'b0};
      bit_val  = ppg_pkg::ROOT_W'(1) << shamt;
      trial    = root_next + bit_val;
      if (rem_next >= trial) begin
        rem_next  = rem_next - trial;
        root_next = (root_next >> 1) + bit_val;
      end else begin
        root_next = root_next >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

// ----- rtl/ppg_sine_rom.sv -----
// Quarter-wave sine lookup with registered read; angle in turns, result signed Q15.
module ppg_sine_rom (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [15:0] sine
);

  logic [ppg_pkg::SINE_IDX_W-1:0] idx;
  logic [14:0]                    mag;
  logic                           neg;

  // Odd quadrants run the table backwards.
  assign idx = phase[30] ? ~phase[29 -: ppg_pkg::SINE_IDX_W]
                         : phase[29 -: ppg_pkg::SINE_IDX_W];

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= ppg_pkg::SINE_TABLE[idx];
      neg <= phase[31];
    end
  end

  assign sine = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
